// ===== rtl/ist_pkg.sv =====
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants for the integer set table: opcodes, status
// codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ist_pkg;

	localparam int VALUE_W = 31;
	localparam int WORD_W  = VALUE_W + 1;

	typedef logic [1:0] opcode_t;
	typedef logic [1:0] status_t;

	localparam opcode_t OP_INSERT = 2'd0;
	localparam opcode_t OP_DELETE = 2'd1;
	localparam opcode_t OP_LOOKUP = 2'd2;

	localparam status_t STAT_OK      = 2'd0;
	localparam status_t STAT_PRESENT = 2'd1;
	localparam status_t STAT_ABSENT  = 2'd2;
	localparam status_t STAT_FULL    = 2'd3;

	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic update;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic scan_done;
	} dp_stat_t;

endpackage

// ===== rtl/integer_set_table_core.sv =====
// ----------------------------------------------------------------------------
// integer_set_table_core
// Fixed-capacity set of 31-bit non-negative integers with insert, delete and
// lookup, one result per operation.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the slot memory and holds
// in_stall high until it is done. For each operation the single read port of
// the slot memory is walked once over every slot to find a match and the
// lowest free slot, then an update step applies the update once the output
// register can take the result. One operation is in flight at a time; the
// next input transfer is taken as soon as the result sits in the output
// register, even if the receiver still stalls it. Unused opcode three
// behaves as a lookup. The element_count output carries the low 8 bits of
// the count.
module integer_set_table_core #(
	parameter int SET_SIZE = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ist_pkg::opcode_t opcode,
	input  logic [30:0]      value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             found,
	output ist_pkg::status_t status,
	output logic [7:0]       element_count
);
	import ist_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	ist_datapath #(
		.SET_SIZE (SET_SIZE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.opcode        (opcode),
		.value         (value),
		.found         (found),
		.status        (status),
		.element_count (element_count)
	);

endmodule

// ===== rtl/ist_datapath.sv =====
// ----------------------------------------------------------------------------
// ist_datapath
// Slot memory, sequential match / free-slot scan, element counter and the
// result register.
// ----------------------------------------------------------------------------
module ist_datapath #(
	parameter int SET_SIZE = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ist_pkg::dp_cmd_t  cmd,
	output ist_pkg::dp_stat_t stat,
	input  ist_pkg::opcode_t  opcode,
	input  logic [30:0]       value,
	output logic              found,
	output ist_pkg::status_t  status,
	output logic [7:0]        element_count
);
	import ist_pkg::*;

	localparam int AW = $clog2(SET_SIZE);
	localparam int CW = $clog2(SET_SIZE + 1);
	localparam logic [AW:0]   SCAN_END = (AW + 1)'(SET_SIZE);
	localparam logic [AW-1:0] LAST_IDX = AW'(SET_SIZE - 1);
	localparam logic [CW-1:0] COUNT_ONE = CW'(1);

	// each word holds a valid flag above the stored value
	logic [WORD_W-1:0] mem [SET_SIZE];

	opcode_t            op_q;
	logic [VALUE_W-1:0] value_q;
	logic [AW-1:0]      clr_idx_q;
	logic [AW:0]        rd_idx_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic [WORD_W-1:0]  rd_data_s1;
	logic               hit_q;
	logic [AW-1:0]      hit_idx_q;
	logic               free_q;
	logic [AW-1:0]      free_idx_q;
	logic [CW-1:0]      count_q;
	logic               found_q;
	status_t            status_q;
	logic [CW+7:0]      count_ext;
	logic [7:0]         elem_q;

	logic               rd_en;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [WORD_W-1:0]  wr_data;
	logic               upd_ins;
	logic               upd_del;
	status_t            nxt_status;
	logic [CW-1:0]      nxt_count;

	assign rd_en = cmd.scan && (rd_idx_q != SCAN_END);

	assign stat.scan_done  = cmd.scan && (rd_idx_q == SCAN_END) && !rd_vld_s1;
	assign stat.clear_done = cmd.clear && (clr_idx_q == LAST_IDX);

	// outcome of the scanned operation
	always_comb begin
		upd_ins    = 1'b0;
		upd_del    = 1'b0;
		nxt_status = STAT_OK;
		nxt_count  = count_q;
		case (op_q)
			OP_INSERT: begin
				if (hit_q) begin
					nxt_status = STAT_PRESENT;
				end else if (free_q) begin
					upd_ins   = 1'b1;
					nxt_count = count_q + COUNT_ONE;
				end else begin
					nxt_status = STAT_FULL;
				end
			end
			OP_DELETE: begin
				if (hit_q) begin
					upd_del   = 1'b1;
					nxt_count = count_q - COUNT_ONE;
				end else begin
					nxt_status = STAT_ABSENT;
				end
			end
			OP_LOOKUP: nxt_status = hit_q ? STAT_OK : STAT_ABSENT;
			default:   nxt_status = hit_q ? STAT_OK : STAT_ABSENT;
		endcase
	end

	always_comb begin
		wr_en   = cmd.clear || (cmd.update && (upd_ins || upd_del));
		wr_addr = hit_idx_q;
		wr_data = {1'b0, value_q};
		if (cmd.clear) begin
			wr_addr = clr_idx_q;
			wr_data = '0;
		end else if (upd_ins) begin
			wr_addr = free_idx_q;
			wr_data = {1'b1, value_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			count_q    <= '0;
		end else begin
			if (cmd.clear) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			if (cmd.load) begin
				rd_idx_q  <= '0;
				rd_vld_s1 <= 1'b0;
				hit_q     <= 1'b0;
				free_q    <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					rd_idx_q  <= rd_idx_q + (AW + 1)'(1);
					rd_idx_s1 <= rd_idx_q[AW-1:0];
				end
				// compare the word read in the previous cycle
				if (rd_vld_s1) begin
					if (rd_data_s1[WORD_W-1] && (rd_data_s1[VALUE_W-1:0] == value_q) && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= rd_idx_s1;
					end
					if (!rd_data_s1[WORD_W-1] && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= rd_idx_s1;
					end
				end
			end
			if (cmd.update) begin
				count_q <= nxt_count;
			end
		end
	end

	assign count_ext = {8'd0, nxt_count};

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			found_q  <= hit_q;
			status_q <= nxt_status;
			elem_q   <= count_ext[7:0];
		end
	end

	assign found         = found_q;
	assign status        = status_q;
	assign element_count = elem_q;

endmodule

// ===== rtl/ist_ctrl.sv =====
// ----------------------------------------------------------------------------
// ist_ctrl
// Sequencer for the set table: clearing pass after reset, input transfer,
// slot scan, update, and the output valid flag.
// ----------------------------------------------------------------------------
module ist_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output ist_pkg::dp_cmd_t  cmd,
	input  ist_pkg::dp_stat_t stat
);
	import ist_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt  = state_q;
		cmd.clear  = 1'b0;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.update = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				// hold until the result register can take the new result
				if (out_free) begin
					cmd.update = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sim/integer_set_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// integer_set_table_core_tb
// Self-checking bench for the integer set table. A shadow copy of the slot
// array predicts found, status and element count for every accepted operation.
// Stimulus is a short directed sequence, then fill-to-full / drain rounds and
// a mixed phase over a small value pool, with random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_set_table_core_tb;
	import ist_pkg::*;

	localparam int SET_SIZE = 128;
	localparam opcode_t OP_SPARE = 2'd3;
	localparam int IDLE_PCT = 21;
	localparam int ITEM_TARGET = 1000;

	typedef struct {
		logic       found;
		status_t    status;
		logic [7:0] count;
	} reply_t;

	class set_shadow;
		logic [30:0] vals[SET_SIZE];
		bit          used[SET_SIZE];
		int          count;
		int          errors;
		int          replies;
		reply_t      pending[$];

		function new();
			count = 0;
			errors = 0;
			replies = 0;
			foreach (used[i])
				used[i] = 0;
		endfunction

		task flag(input string msg);
			$display("mismatch at reply %0d: %s", replies, msg);
			errors++;
		endtask

		// value held in a randomly chosen occupied slot, set must not be empty
		function logic [30:0] pick_stored();
			int k;
			k = $urandom_range(SET_SIZE - 1);
			while (!used[k])
				k = (k + 1) % SET_SIZE;
			return vals[k];
		endfunction

		function void apply_op(input opcode_t op, input logic [30:0] v);
			reply_t r;
			int hit;
			int gap;
			hit = -1;
			gap = -1;
			for (int i = 0; i < SET_SIZE; i++) begin
				if (used[i] && vals[i] == v && hit < 0)
					hit = i;
				if (!used[i] && gap < 0)
					gap = i;
			end
			r.found = (hit >= 0);
			case (op)
				OP_INSERT: begin
					if (hit >= 0) begin
						r.status = STAT_PRESENT;
					end else if (gap >= 0) begin
						vals[gap] = v;
						used[gap] = 1;
						count++;
						r.status = STAT_OK;
					end else begin
						r.status = STAT_FULL;
					end
				end
				OP_DELETE: begin
					if (hit >= 0) begin
						used[hit] = 0;
						count--;
						r.status = STAT_OK;
					end else begin
						r.status = STAT_ABSENT;
					end
				end
				// lookup and the spare opcode leave the set alone
				default: r.status = (hit >= 0) ? STAT_OK : STAT_ABSENT;
			endcase
			r.count = count[7:0];
			pending.push_back(r);
		endfunction

		task check_reply(input logic f, input status_t s, input logic [7:0] c);
			reply_t e;
			if (pending.size() == 0) begin
				flag("result with nothing outstanding");
			end else begin
				e = pending.pop_front();
				if (f !== e.found)
					flag($sformatf("found got %b exp %b", f, e.found));
				if (s !== e.status)
					flag($sformatf("status got %0d exp %0d", s, e.status));
				if (c !== e.count)
					flag($sformatf("element_count got %0d exp %0d", c, e.count));
			end
			replies++;
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	opcode_t     opcode = OP_LOOKUP;
	logic [30:0] value = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        found;
	status_t     status;
	logic [7:0]  element_count;

	set_shadow   shadow;
	bit          calm = 0;
	int          issued = 0;
	logic [30:0] pool[24];

	integer_set_table_core #(
		.SET_SIZE(SET_SIZE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.status(status),
		.element_count(element_count)
	);

	always #5 clk = ~clk;

	// result side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.check_reply(found, status, element_count);
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	task automatic send_op(input opcode_t op, input logic [30:0] v);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		value <= v;
		do @(posedge clk); while (in_stall);
		shadow.apply_op(op, v);
		issued++;
	endtask

	// sender goes idle until every outstanding result has come back
	task automatic wait_drained();
		in_valid <= 0;
		while (shadow.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [30:0] rand_value();
		return 31'($urandom());
	endfunction

	task automatic directed_ops();
		send_op(OP_LOOKUP, 31'd0);
		send_op(OP_DELETE, 31'd5);
		send_op(OP_INSERT, 31'd0);
		send_op(OP_INSERT, 31'h7FFF_FFFF);
		send_op(OP_INSERT, 31'd0);
		send_op(OP_LOOKUP, 31'h7FFF_FFFF);
		send_op(OP_LOOKUP, 31'h2AAA_AAAA);
		send_op(OP_SPARE, 31'd0);
		send_op(OP_SPARE, 31'h5555_5555);
		send_op(OP_INSERT, 31'h5555_5555);
		send_op(OP_INSERT, 31'h2AAA_AAAA);
		send_op(OP_DELETE, 31'd0);
		// freed slot zero is reused first
		send_op(OP_INSERT, 31'd123);
		send_op(OP_DELETE, 31'h7FFF_FFFF);
		send_op(OP_DELETE, 31'h7FFF_FFFF);
		send_op(OP_LOOKUP, 31'd123);
		send_op(OP_DELETE, 31'd123);
		send_op(OP_DELETE, 31'h5555_5555);
		send_op(OP_DELETE, 31'h2AAA_AAAA);
	endtask

	task automatic fill_drain_round(input bit hold_off);
		int r;
		while (shadow.count < SET_SIZE) begin
			r = $urandom_range(99);
			if (r < 80 || shadow.count == 0)
				send_op(OP_INSERT, rand_value());
			else if (r < 88)
				send_op(OP_INSERT, shadow.pick_stored());
			else if (r < 94)
				send_op(OP_LOOKUP, shadow.pick_stored());
			else
				send_op(OP_DELETE, rand_value());
		end
		// full set: new values bounce, a stored one still reports present
		repeat (5) send_op(OP_INSERT, rand_value());
		send_op(OP_INSERT, shadow.pick_stored());
		if (hold_off)
			wait_drained();
		send_op(OP_DELETE, shadow.vals[SET_SIZE - 1]);
		send_op(OP_INSERT, rand_value());
		send_op(OP_DELETE, shadow.pick_stored());
		send_op(OP_INSERT, rand_value());
		send_op(OP_INSERT, rand_value());
		while (shadow.count > 0) begin
			r = $urandom_range(99);
			if (r < 80)
				send_op(OP_DELETE, shadow.pick_stored());
			else if (r < 88)
				send_op(OP_LOOKUP, shadow.pick_stored());
			else if (r < 94)
				send_op(OP_SPARE, shadow.pick_stored());
			else
				send_op(OP_DELETE, rand_value());
		end
	endtask

	task automatic mixed_ops(input int n);
		int r;
		logic [30:0] v;
		repeat (n) begin
			v = ($urandom_range(9) == 0) ? rand_value() : pool[$urandom_range(23)];
			r = $urandom_range(99);
			if (r < 40)
				send_op(OP_INSERT, v);
			else if (r < 65)
				send_op(OP_DELETE, v);
			else if (r < 92)
				send_op(OP_LOOKUP, v);
			else
				send_op(OP_SPARE, v);
		end
	endtask

	initial begin
		shadow = new();
		foreach (pool[i])
			pool[i] = rand_value();
		pool[0] = 31'd0;
		pool[1] = 31'h7FFF_FFFF;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		directed_ops();
		fill_drain_round(1);
		calm = 1;
		mixed_ops(150);
		calm = 0;
		mixed_ops(ITEM_TARGET - 330 - issued > 50 ? ITEM_TARGET - 330 - issued : 50);
		// clear out whatever the mixed phase left before the second round
		while (shadow.count > 0)
			send_op(OP_DELETE, shadow.pick_stored());
		fill_drain_round(0);

		wait_drained();
		repeat (SET_SIZE + 8) @(posedge clk);
		if (shadow.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#8ms;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ist_pkg.sv
rtl/ist_datapath.sv
rtl/ist_ctrl.sv
rtl/integer_set_table_core.sv
sim/integer_set_table_core_tb.sv
